// ===== hdl/numeric_char_ref_to_utf8_macros.svh =====
// assertion helpers used by the checker file
`ifndef NUMERIC_CHAR_REF_TO_UTF8_MACROS_SVH
`define NUMERIC_CHAR_REF_TO_UTF8_MACROS_SVH

// same-cycle implication
`define NCR_ASSERT_NOW(lbl, clk, dis, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NCR_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ncr_pkg.sv =====
package ncr_pkg;

   localparam int unsigned MaxResults = 6;

   typedef struct packed {
      logic [MaxResults-1:0][7:0] bytes;
      logic [2:0]                 count;
      logic                       error;
   } burst_type;

   localparam logic [7:0] CharAmp  = 8'h26;
   localparam logic [7:0] CharHash = 8'h23;
   localparam logic [7:0] CharSemi = 8'h3b;
   localparam logic [7:0] CharLowX = 8'h78;
   localparam logic [7:0] CharUpX  = 8'h58;
   localparam logic [7:0] Char0    = 8'h30;
   localparam logic [7:0] Char9    = 8'h39;
   localparam logic [7:0] CharUpA  = 8'h41;
   localparam logic [7:0] CharUpF  = 8'h46;
   localparam logic [7:0] CharLowA = 8'h61;
   localparam logic [7:0] CharLowF = 8'h66;

   localparam logic [7:0] Lead2    = 8'hc0;
   localparam logic [7:0] Lead3    = 8'he0;
   localparam logic [7:0] Lead4    = 8'hf0;
   localparam logic [7:0] Lead5    = 8'hf8;
   localparam logic [7:0] Lead6    = 8'hfc;
   localparam logic [7:0] ContMark = 8'h80;

   // code point (31 bits) to a burst of 1 to 6 utf-8 bytes, first byte in slot 0
   function automatic burst_type utf8_encode(logic [30:0] cp);
      burst_type  res;
      logic [7:0] c0;
      logic [7:0] c1;
      logic [7:0] c2;
      logic [7:0] c3;
      logic [7:0] c4;
      res = '0;
      c0 = ContMark | {2'b00, cp[5:0]};
      c1 = ContMark | {2'b00, cp[11:6]};
      c2 = ContMark | {2'b00, cp[17:12]};
      c3 = ContMark | {2'b00, cp[23:18]};
      c4 = ContMark | {2'b00, cp[29:24]};
      priority if (cp[30:26] != 5'd0) begin
         res.bytes[0] = Lead6 | {7'd0, cp[30]};
         res.bytes[1] = c4;
         res.bytes[2] = c3;
         res.bytes[3] = c2;
         res.bytes[4] = c1;
         res.bytes[5] = c0;
         res.count    = 3'd6;
      end else if (cp[25:21] != 5'd0) begin
         res.bytes[0] = Lead5 | {6'd0, cp[25:24]};
         res.bytes[1] = c3;
         res.bytes[2] = c2;
         res.bytes[3] = c1;
         res.bytes[4] = c0;
         res.count    = 3'd5;
      end else if (cp[20:16] != 5'd0) begin
         res.bytes[0] = Lead4 | {5'd0, cp[20:18]};
         res.bytes[1] = c2;
         res.bytes[2] = c1;
         res.bytes[3] = c0;
         res.count    = 3'd4;
      end else if (cp[15:11] != 5'd0) begin
         res.bytes[0] = Lead3 | {4'd0, cp[15:12]};
         res.bytes[1] = c1;
         res.bytes[2] = c0;
         res.count    = 3'd3;
      end else if (cp[10:7] != 4'd0) begin
         res.bytes[0] = Lead2 | {3'd0, cp[10:6]};
         res.bytes[1] = c0;
         res.count    = 3'd2;
      end else begin
         res.bytes[0] = {1'b0, cp[6:0]};
         res.count    = 3'd1;
      end
      return res;
   endfunction

endpackage

// ===== hdl/numeric_char_ref_to_utf8.sv =====
// Numeric character reference decoder with UTF-8 output.
// Request channel: req_valid / req_stall carry one text byte (req_in_byte).
// Response channel: rsp_valid / rsp_stall carry one output byte with
// rsp_last (final byte caused by that request) and rsp_error (malformed or
// overflowed reference; the offending byte is returned, alone).
// Plain bytes pass through; &#ddd; and &#xhh; become 1 to 6 UTF-8 bytes.
// A request that yields results shows its first byte in the cycle after it
// is accepted. Bytes of a burst leave at one per cycle from the output
// shift register while rsp_stall is low; a new request is taken every
// cycle the register is empty or giving up its last byte. Requests that
// yield nothing (inside a reference) are taken one per cycle while the
// output register is free. The output register is the only rate limit:
// throughput is one request per cycle for plain text while rsp_stall is low.
// Reset (synchronous) empties the output register and returns the parser
// to plain text. While rsp_stall is high the shown byte holds, and
// req_stall rises once the output register is busy.
module numeric_char_ref_to_utf8 (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last,
   output logic       rsp_error
);

   ncr_pkg::burst_type burst;
   logic               free;
   logic               accept;

   assign req_stall = !free;
   assign accept    = req_valid && free;

   ncr_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_in_byte),
      .burst   (burst)
   );

   ncr_burst u_burst (
      .clock        (clock),
      .reset        (reset),
      .load         (accept),
      .load_burst   (burst),
      .free         (free),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_error    (rsp_error)
   );

endmodule

// ===== hdl/ncr_parse.sv =====
module ncr_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         in_byte,
   output ncr_pkg::burst_type burst
);

   typedef enum logic [2:0] {
      ModeIdle = 3'd0,
      ModeAmp  = 3'd1,
      ModeHash = 3'd2,
      ModeHex  = 3'd3,
      ModeDec  = 3'd4
   } mode_type;

   mode_type    mode_ff;
   mode_type    mode_in;
   logic [30:0] acc_ff;
   logic [30:0] acc_in;

   logic        use_hex;
   logic        in_ref;
   logic        is_dec;
   logic        is_hex_letter;
   logic        is_digit;
   logic [3:0]  digit;
   logic [34:0] hex_sum;
   logic [34:0] dec_sum;
   logic [34:0] sum;
   logic        over;

   always_comb begin
      use_hex       = (mode_ff == ModeHex);
      in_ref        = (mode_ff == ModeHash) || (mode_ff == ModeHex) || (mode_ff == ModeDec);
      is_dec        = (in_byte >= ncr_pkg::Char0) && (in_byte <= ncr_pkg::Char9);
      is_hex_letter = ((in_byte >= ncr_pkg::CharUpA) && (in_byte <= ncr_pkg::CharUpF)) ||
                      ((in_byte >= ncr_pkg::CharLowA) && (in_byte <= ncr_pkg::CharLowF));
      is_digit      = is_dec || (use_hex && is_hex_letter);
      // letters a-f and A-F both carry 1..6 in the low nibble
      digit         = is_dec ? in_byte[3:0] : (in_byte[3:0] + 4'd9);
      hex_sum       = {acc_ff, 4'd0} + {31'd0, digit};
      dec_sum       = {1'b0, acc_ff, 3'd0} + {3'd0, acc_ff, 1'b0} + {31'd0, digit};
      sum           = use_hex ? hex_sum : dec_sum;
      over          = (sum[34:31] != 4'd0);

      burst   = '0;
      mode_in = mode_ff;
      acc_in  = acc_ff;

      priority if (mode_ff == ModeAmp) begin
         if (in_byte == ncr_pkg::CharHash) begin
            mode_in = ModeHash;
            acc_in  = '0;
         end else if (in_byte == ncr_pkg::CharAmp) begin
            burst.bytes[0] = ncr_pkg::CharAmp;
            burst.count    = 3'd1;
         end else begin
            mode_in        = ModeIdle;
            burst.bytes[0] = ncr_pkg::CharAmp;
            burst.bytes[1] = in_byte;
            burst.count    = 3'd2;
         end
      end else if (in_ref) begin
         if ((mode_ff == ModeHash) &&
             ((in_byte == ncr_pkg::CharLowX) || (in_byte == ncr_pkg::CharUpX))) begin
            mode_in = ModeHex;
            acc_in  = '0;
         end else if (in_byte == ncr_pkg::CharSemi) begin
            burst   = ncr_pkg::utf8_encode(acc_ff);
            mode_in = ModeIdle;
            acc_in  = '0;
         end else if (!is_digit || over) begin
            burst.bytes[0] = in_byte;
            burst.count    = 3'd1;
            burst.error    = 1'b1;
            mode_in        = ModeIdle;
            acc_in         = '0;
         end else begin
            acc_in  = sum[30:0];
            mode_in = use_hex ? ModeHex : ModeDec;
         end
      end else begin
         acc_in = '0;
         if (in_byte == ncr_pkg::CharAmp) begin
            mode_in = ModeAmp;
         end else begin
            mode_in        = ModeIdle;
            burst.bytes[0] = in_byte;
            burst.count    = 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= ModeIdle;
         acc_ff  <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
      end
   end

endmodule

// ===== hdl/ncr_burst.sv =====
module ncr_burst (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  ncr_pkg::burst_type load_burst,
   output logic               free,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last,
   output logic               rsp_error
);

   logic [ncr_pkg::MaxResults-1:0][7:0] bytes_ff;
   logic [ncr_pkg::MaxResults-1:0][7:0] bytes_in;
   logic [2:0]                          count_ff;
   logic [2:0]                          count_in;
   logic                                error_ff;
   logic                                error_in;
   logic                                taking;

   assign rsp_valid    = (count_ff != 3'd0);
   assign rsp_out_byte = bytes_ff[0];
   assign rsp_last     = (count_ff == 3'd1);
   assign rsp_error    = error_ff;
   assign taking       = rsp_valid && !rsp_stall;
   // room for a new request once the last byte of the current burst leaves
   assign free         = (count_ff == 3'd0) || (taking && (count_ff == 3'd1));

   always_comb begin
      bytes_in = bytes_ff;
      count_in = count_ff;
      error_in = error_ff;
      if (load) begin
         bytes_in = load_burst.bytes;
         count_in = load_burst.count;
         error_in = load_burst.error;
      end else if (taking) begin
         bytes_in = bytes_ff >> 8;
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      error_ff <= error_in;
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/ncr_checker.sv =====
`include "numeric_char_ref_to_utf8_macros.svh"

module ncr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last,
   input logic       rsp_error
);

   // an error is always a single-byte response
   `NCR_ASSERT_NOW(a_error_last, clock, reset, rsp_valid && rsp_error, rsp_last, "error not last")

   // an empty output side never holds off requests
   `NCR_ASSERT_NOW(a_idle_ready, clock, reset, !rsp_valid, !req_stall, "stall while empty")

   `NCR_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "response after reset")

   `NCR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last) && $stable(rsp_error),
                    "stalled response changed")

   // mid-burst bytes keep the request side stalled
   `NCR_ASSERT_NOW(a_burst_block, clock, reset, rsp_valid && !rsp_last, req_stall, "request taken mid-burst")

endmodule

bind numeric_char_ref_to_utf8 ncr_checker u_ncr_checker (.*);

// ===== test/numeric_char_ref_to_utf8_tb.sv =====
`timescale 1ns / 1ps

module numeric_char_ref_to_utf8_tb;

   typedef enum logic [2:0] {
      ModeIdle,
      ModeAmp,
      ModeHash,
      ModeHex,
      ModeDec
   } parse_mode_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       error;
   } utf8_byte_type;

   class ncr_scoreboard;
      parse_mode_type mode;
      logic [31:0]    code;
      utf8_byte_type  utf8_expected[$];
      int unsigned    mismatches;

      function new();
         mode       = ModeIdle;
         code       = '0;
         mismatches = 0;
      endfunction

      function void queue_result(logic [7:0] data, logic last, logic error);
         utf8_byte_type item;
         item.data  = data;
         item.last  = last;
         item.error = error;
         utf8_expected.push_back(item);
      endfunction

      // original 31-bit utf-8 layout, up to six bytes
      function void queue_code_point(logic [31:0] cp);
         int unsigned n;
         int unsigned i;
         logic [7:0]  lead;
         if (cp < 32'h80) begin
            queue_result(cp[7:0], 1'b1, 1'b0);
            return;
         end
         if (cp < 32'h800) begin
            n = 2; lead = ncr_pkg::Lead2;
         end else if (cp < 32'h10000) begin
            n = 3; lead = ncr_pkg::Lead3;
         end else if (cp < 32'h200000) begin
            n = 4; lead = ncr_pkg::Lead4;
         end else if (cp < 32'h4000000) begin
            n = 5; lead = ncr_pkg::Lead5;
         end else begin
            n = 6; lead = ncr_pkg::Lead6;
         end
         queue_result(lead | 8'(cp >> (6 * (n - 1))), 1'b0, 1'b0);
         for (i = 1; i < n; i++) begin
            queue_result(ncr_pkg::ContMark | {2'b00, 6'(cp >> (6 * (n - 1 - i)))},
                         i == n - 1, 1'b0);
         end
      endfunction

      function void take_digit(logic [7:0] b, bit hex);
         logic [31:0] cp;
         logic [3:0]  d;
         logic [63:0] v;
         bit          ok;
         if (b == ncr_pkg::CharSemi) begin
            cp   = code;
            mode = ModeIdle;
            code = '0;
            queue_code_point(cp);
            return;
         end
         ok = 1'b1;
         d  = '0;
         if (b >= ncr_pkg::Char0 && b <= ncr_pkg::Char9) begin
            d = 4'(b - ncr_pkg::Char0);
         end else if (hex && b >= ncr_pkg::CharUpA && b <= ncr_pkg::CharUpF) begin
            d = 4'(b - ncr_pkg::CharUpA + 8'd10);
         end else if (hex && b >= ncr_pkg::CharLowA && b <= ncr_pkg::CharLowF) begin
            d = 4'(b - ncr_pkg::CharLowA + 8'd10);
         end else begin
            ok = 1'b0;
         end
         v = '0;
         if (ok) begin
            v  = {32'd0, code} * (hex ? 64'd16 : 64'd10) + {60'd0, d};
            ok = (v <= 64'h7fff_ffff);
         end
         if (!ok) begin
            queue_result(b, 1'b1, 1'b1);
            mode = ModeIdle;
            code = '0;
            return;
         end
         code = v[31:0];
         if (hex) mode = ModeHex;
         else mode = ModeDec;
      endfunction

      function void note_request(logic [7:0] b);
         case (mode)
            ModeAmp: begin
               if (b == ncr_pkg::CharHash) begin
                  mode = ModeHash;
                  code = '0;
               end else if (b == ncr_pkg::CharAmp) begin
                  queue_result(ncr_pkg::CharAmp, 1'b1, 1'b0);
               end else begin
                  mode = ModeIdle;
                  queue_result(ncr_pkg::CharAmp, 1'b0, 1'b0);
                  queue_result(b, 1'b1, 1'b0);
               end
            end
            ModeHash: begin
               if (b == ncr_pkg::CharLowX || b == ncr_pkg::CharUpX) begin
                  mode = ModeHex;
                  code = '0;
               end else begin
                  take_digit(b, 1'b0);
               end
            end
            ModeHex: take_digit(b, 1'b1);
            ModeDec: take_digit(b, 1'b0);
            default: begin
               mode = ModeIdle;
               code = '0;
               if (b == ncr_pkg::CharAmp) mode = ModeAmp;
               else queue_result(b, 1'b1, 1'b0);
            end
         endcase
      endfunction

      function void check_response(logic [7:0] data, logic last, logic error);
         utf8_byte_type want;
         if (utf8_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: byte=%02h last=%0b error=%0b", data, last, error);
            return;
         end
         want = utf8_expected.pop_front();
         if (data !== want.data || last !== want.last || error !== want.error) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected byte=%02h last=%0b error=%0b, got %02h %0b %0b",
                        want.data, want.last, want.error, data, last, error);
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_last;
   logic       rsp_error;

   ncr_scoreboard ncr_sb = new();
   bit            gaps_on = 1'b1;
   int unsigned   bytes_sent = 0;

   numeric_char_ref_to_utf8 u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_error    (rsp_error)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) ncr_sb.check_response(rsp_out_byte, rsp_last, rsp_error);
         rsp_stall <= gaps_on && ($urandom_range(99) < 26);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while (gaps_on && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ncr_sb.note_request(b);
      bytes_sent++;
   endtask

   task automatic send_string(input string s);
      int i;
      for (i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ncr_sb.utf8_expected.size() != 0) @(posedge clock);
   endtask

   task automatic send_digits(input logic [31:0] value, input bit hex);
      logic [7:0]  digits[$];
      logic [31:0] v;
      logic [31:0] dv;
      logic [7:0]  letter;
      v = value;
      do begin
         dv = hex ? (v % 32'd16) : (v % 32'd10);
         letter = $urandom_range(1) ? ncr_pkg::CharUpA : ncr_pkg::CharLowA;
         if (dv < 10) digits.push_front(ncr_pkg::Char0 + 8'(dv));
         else digits.push_front(letter + 8'(dv - 10));
         v = hex ? (v / 32'd16) : (v / 32'd10);
      end while (v != 0);
      foreach (digits[i]) send_byte(digits[i]);
   endtask

   task automatic send_reference(input logic [31:0] value, input bit hex);
      int unsigned zeros;
      zeros = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0;
      send_byte(ncr_pkg::CharAmp);
      send_byte(ncr_pkg::CharHash);
      if (hex) send_byte($urandom_range(1) ? ncr_pkg::CharUpX : ncr_pkg::CharLowX);
      repeat (zeros) send_byte(ncr_pkg::Char0);
      send_digits(value, hex);
      send_byte(ncr_pkg::CharSemi);
   endtask

   // reference cut short by a newline or any random byte
   task automatic send_broken();
      bit hex;
      hex = 1'($urandom_range(1));
      send_byte(ncr_pkg::CharAmp);
      send_byte(ncr_pkg::CharHash);
      if (hex) send_byte(ncr_pkg::CharLowX);
      repeat ($urandom_range(3)) send_byte(ncr_pkg::Char0 + 8'($urandom_range(9)));
      send_byte($urandom_range(1) ? 8'h0a : 8'($urandom_range(255)));
   endtask

   initial begin
      int unsigned kind;
      int unsigned nbits;
      logic [31:0] cp;
      bit          drained;

      drained = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_byte(8'h00);
      send_byte(8'hff);
      send_string("&&z&#;&#X;&#\n&#xg&#9a");
      wait_for_drain();

      while (bytes_sent < 470) begin
         gaps_on = !(bytes_sent >= 150 && bytes_sent < 250);
         if (!drained && bytes_sent >= 300) begin
            wait_for_drain();
            drained = 1'b1;
         end
         kind = $urandom_range(99);
         if (kind < 20) begin
            send_byte(8'($urandom_range(255)));
         end else if (kind < 70) begin
            // pick the bit length first so every utf-8 length shows up
            nbits = $urandom_range(31);
            if (nbits == 0) cp = '0;
            else cp = ($urandom & ((32'd1 << nbits) - 1)) | (32'd1 << (nbits - 1));
            if ($urandom_range(7) == 0) cp = 32'h7fff_ffff;
            send_reference(cp, 1'($urandom_range(1)));
         end else if (kind < 80) begin
            if ($urandom_range(1)) cp = 32'h8000_0000 | $urandom;
            else cp = 32'h7fff_ffff + $urandom_range(1, 16);
            send_reference(cp, 1'($urandom_range(1)));
         end else if (kind < 90) begin
            send_broken();
         end else begin
            send_byte(ncr_pkg::CharAmp);
            send_byte($urandom_range(3) == 0 ? ncr_pkg::CharAmp : 8'($urandom_range(255)));
         end
      end

      gaps_on = 1'b1;
      wait_for_drain();
      repeat (20) @(posedge clock);
      if (ncr_sb.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
